FILE: rtl/jpeg_segment_carver_defines.svh
// Assertion macros used by the carver top level
`ifndef JPEG_SEGMENT_CARVER_DEFINES_SVH
`define JPEG_SEGMENT_CARVER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define JSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsc assertion failed");

// Next-cycle implication, checked out of reset
`define JSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsc assertion failed");

`endif

FILE: rtl/jsc_pkg.sv
// Constants and codes for the JPEG segment carver
`timescale 1ns / 1ps

package jsc_pkg;

    localparam int unsigned LimitWidth   = 24;
    localparam int unsigned LengthWidth  = 25;
    localparam int unsigned CountWidth   = 32;
    localparam int unsigned VerdictWidth = 3;
    localparam int unsigned PhaseWidth   = 4;

    localparam logic [LimitWidth-1:0]  LengthLimitReset = 24'd15728640;
    localparam logic [LengthWidth-1:0] PositionMax      = 25'h1000000;

    // marker bytes
    localparam logic [7:0] MarkFf   = 8'hFF;
    localparam logic [7:0] MarkApp0 = 8'hE0;
    localparam logic [7:0] MarkExif = 8'hE1;
    localparam logic [7:0] MarkEd   = 8'hED;
    localparam logic [7:0] MarkSoi  = 8'hD8;
    localparam logic [7:0] MarkDqt  = 8'hDB;
    localparam logic [7:0] MarkEoi  = 8'hD9;

    // verdict codes
    localparam logic [VerdictWidth-1:0] VerdictNoApp    = 3'd0;
    localparam logic [VerdictWidth-1:0] VerdictExtract  = 3'd1;
    localparam logic [VerdictWidth-1:0] VerdictTooLong  = 3'd2;
    localparam logic [VerdictWidth-1:0] VerdictDataEnd  = 3'd3;
    localparam logic [VerdictWidth-1:0] VerdictNotStart = 3'd4;

    // parse phases
    localparam logic [PhaseWidth-1:0] PhIdle = 4'd0;
    localparam logic [PhaseWidth-1:0] PhSoi0 = 4'd1;
    localparam logic [PhaseWidth-1:0] PhSoi1 = 4'd2;
    localparam logic [PhaseWidth-1:0] PhMark = 4'd3;
    localparam logic [PhaseWidth-1:0] PhType = 4'd4;
    localparam logic [PhaseWidth-1:0] PhLenH = 4'd5;
    localparam logic [PhaseWidth-1:0] PhLenL = 4'd6;
    localparam logic [PhaseWidth-1:0] PhSkip = 4'd7;
    localparam logic [PhaseWidth-1:0] PhScan = 4'd8;
    localparam logic [PhaseWidth-1:0] PhDone = 4'd9;

endpackage

FILE: rtl/jpeg_segment_carver.sv
// Top level of the JPEG segment carver: marker walker, counters and verdict register
//
// Usage:
//  Input channel (i_in_valid / o_in_stall) carries one byte of a candidate image per
//  transaction, with i_first_byte marking the start of a candidate and i_end_of_data
//  closing it. Output channel (o_out_valid / i_out_stall) carries at most one verdict
//  per input transaction, together with the image length and the running segment counts.
//  Configuration channel (i_cfg_valid / o_cfg_ready) writes length_limit; it is always
//  ready and should only be written while no candidate is in flight.
//  A verdict is registered, so it appears in the cycle after the byte that causes it.
//  Throughput: one byte per unstalled cycle; parse state is updated in the accept cycle.
//  When the receiver stalls while a verdict is pending, o_in_stall rises and holds the
//  input until that verdict is taken; the counts shown stay fixed meanwhile.
//  Reset (synchronous, active low) returns the parser to idle, clears all counts and
//  loads length_limit with 15728640.
`timescale 1ns / 1ps
`include "jpeg_segment_carver_defines.svh"

module jpeg_segment_carver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_first_byte,
    input  logic                                i_end_of_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [jsc_pkg::VerdictWidth-1:0]    o_verdict,
    output logic [jsc_pkg::LengthWidth-1:0]     o_image_length,
    output logic [jsc_pkg::CountWidth-1:0]      o_app0_total,
    output logic [jsc_pkg::CountWidth-1:0]      o_exif_total,
    output logic [jsc_pkg::CountWidth-1:0]      o_ffed_total,
    output logic [jsc_pkg::CountWidth-1:0]      o_ffd8_total,
    output logic [jsc_pkg::CountWidth-1:0]      o_ffdb_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jsc_pkg::LimitWidth-1:0]      i_cfg_length_limit
);

    logic [jsc_pkg::LimitWidth-1:0]   r_length_limit;
    logic [jsc_pkg::PhaseWidth-1:0]   r_phase, n_phase;
    logic [15:0]                      r_skip, n_skip;
    logic [7:0]                       r_seg_type, n_seg_type;
    logic [7:0]                       r_len_high, n_len_high;
    logic                             r_app_seen, n_app_seen;
    logic                             r_prev_ff, n_prev_ff;
    logic [jsc_pkg::LengthWidth-1:0]  r_pos, n_pos;
    logic [jsc_pkg::CountWidth-1:0]   r_app0, n_app0;
    logic [jsc_pkg::CountWidth-1:0]   r_exif, n_exif;
    logic [jsc_pkg::CountWidth-1:0]   r_ffed, n_ffed;
    logic [jsc_pkg::CountWidth-1:0]   r_ffd8, n_ffd8;
    logic [jsc_pkg::CountWidth-1:0]   r_ffdb, n_ffdb;
    logic                             r_out_valid, n_out_valid;
    logic [jsc_pkg::VerdictWidth-1:0] r_verdict, n_verdict;
    logic [jsc_pkg::LengthWidth-1:0]  r_image_length, n_image_length;

    logic                             in_accept;
    logic                             out_take;
    logic [jsc_pkg::PhaseWidth-1:0]   eff_phase;
    logic                             eff_app_seen;
    logic [jsc_pkg::LengthWidth-1:0]  eff_pos;
    logic [jsc_pkg::LengthWidth-1:0]  pos_inc;
    logic [15:0]                      seg_size;
    logic                             emit;
    logic [jsc_pkg::VerdictWidth-1:0] emit_verdict;
    logic [jsc_pkg::LengthWidth-1:0]  emit_length;

    // a pending verdict that is not being taken blocks new input
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign out_take    = r_out_valid & ~i_out_stall;
    assign o_cfg_ready = 1'b1;

    // first byte restarts the candidate before the byte itself is parsed
    assign eff_phase    = i_first_byte ? jsc_pkg::PhSoi0 : r_phase;
    assign eff_app_seen = i_first_byte ? 1'b0 : r_app_seen;
    assign eff_pos      = i_first_byte ? '0 : r_pos;
    assign pos_inc      = eff_pos + jsc_pkg::LengthWidth'(eff_pos != jsc_pkg::PositionMax);
    assign seg_size     = {r_len_high, i_data_byte};

    always_comb begin
        n_phase      = r_phase;
        n_skip       = r_skip;
        n_seg_type   = r_seg_type;
        n_len_high   = r_len_high;
        n_app_seen   = r_app_seen;
        n_prev_ff    = r_prev_ff;
        n_pos        = r_pos;
        n_app0       = r_app0;
        n_exif       = r_exif;
        n_ffed       = r_ffed;
        n_ffd8       = r_ffd8;
        n_ffdb       = r_ffdb;
        emit         = 1'b0;
        emit_verdict = jsc_pkg::VerdictNoApp;
        emit_length  = '0;

        if (in_accept) begin
            if (i_first_byte) begin
                n_phase    = jsc_pkg::PhSoi0;
                n_skip     = '0;
                n_seg_type = '0;
                n_len_high = '0;
                n_app_seen = 1'b0;
                n_prev_ff  = 1'b0;
                n_pos      = '0;
            end

            if (eff_phase == jsc_pkg::PhIdle || eff_phase >= jsc_pkg::PhDone) begin
                // outside a candidate: byte ignored
            end else if (i_end_of_data) begin
                emit = 1'b1;
                case (eff_phase)
                    jsc_pkg::PhSoi0, jsc_pkg::PhSoi1: begin
                        emit_verdict = jsc_pkg::VerdictNotStart;
                    end
                    jsc_pkg::PhMark, jsc_pkg::PhSkip: begin
                        emit_verdict = eff_app_seen ? jsc_pkg::VerdictDataEnd
                                                    : jsc_pkg::VerdictNoApp;
                    end
                    default: begin
                        emit_verdict = jsc_pkg::VerdictDataEnd;
                    end
                endcase
            end else begin
                n_pos = pos_inc;
                case (eff_phase)
                    jsc_pkg::PhSoi0: begin
                        if (i_data_byte != jsc_pkg::MarkFf) begin
                            emit         = 1'b1;
                            emit_verdict = jsc_pkg::VerdictNotStart;
                        end else begin
                            n_phase = jsc_pkg::PhSoi1;
                        end
                    end
                    jsc_pkg::PhSoi1: begin
                        if (i_data_byte != jsc_pkg::MarkSoi) begin
                            emit         = 1'b1;
                            emit_verdict = jsc_pkg::VerdictNotStart;
                        end else begin
                            n_phase = jsc_pkg::PhMark;
                        end
                    end
                    jsc_pkg::PhMark: begin
                        if (i_data_byte == jsc_pkg::MarkFf) begin
                            n_phase = jsc_pkg::PhType;
                        end else if (eff_app_seen) begin
                            // the byte that ends the walk never counts as the FF of FF D9
                            n_prev_ff = 1'b0;
                            n_phase   = jsc_pkg::PhScan;
                        end else begin
                            emit         = 1'b1;
                            emit_verdict = jsc_pkg::VerdictNoApp;
                        end
                    end
                    jsc_pkg::PhType: begin
                        n_seg_type = i_data_byte;
                        n_phase    = jsc_pkg::PhLenH;
                    end
                    jsc_pkg::PhLenH: begin
                        n_len_high = i_data_byte;
                        n_phase    = jsc_pkg::PhLenL;
                    end
                    jsc_pkg::PhLenL: begin
                        case (r_seg_type)
                            jsc_pkg::MarkApp0: begin
                                n_app0     = r_app0 + jsc_pkg::CountWidth'(1);
                                n_app_seen = 1'b1;
                            end
                            jsc_pkg::MarkExif: begin
                                n_exif     = r_exif + jsc_pkg::CountWidth'(1);
                                n_app_seen = 1'b1;
                            end
                            jsc_pkg::MarkEd:  n_ffed = r_ffed + jsc_pkg::CountWidth'(1);
                            jsc_pkg::MarkSoi: n_ffd8 = r_ffd8 + jsc_pkg::CountWidth'(1);
                            jsc_pkg::MarkDqt: n_ffdb = r_ffdb + jsc_pkg::CountWidth'(1);
                            default: ;
                        endcase
                        // lengths below 2 skip nothing
                        if (seg_size > 16'd2) begin
                            n_skip  = seg_size - 16'd2;
                            n_phase = jsc_pkg::PhSkip;
                        end else begin
                            n_skip  = '0;
                            n_phase = jsc_pkg::PhMark;
                        end
                    end
                    jsc_pkg::PhSkip: begin
                        n_skip = r_skip - 16'd1;
                        if (r_skip == 16'd1) begin
                            n_phase = jsc_pkg::PhMark;
                        end
                    end
                    jsc_pkg::PhScan: begin
                        if (r_prev_ff && i_data_byte == jsc_pkg::MarkEoi) begin
                            emit         = 1'b1;
                            emit_length  = pos_inc;
                            emit_verdict = (pos_inc < {1'b0, r_length_limit})
                                         ? jsc_pkg::VerdictExtract
                                         : jsc_pkg::VerdictTooLong;
                        end else begin
                            n_prev_ff = (i_data_byte == jsc_pkg::MarkFf);
                        end
                    end
                    default: ;
                endcase
            end

            if (emit) begin
                n_phase = jsc_pkg::PhDone;
            end
        end
    end

    // output register: loads on a verdict, clears once taken
    always_comb begin
        n_out_valid    = r_out_valid & ~out_take;
        n_verdict      = r_verdict;
        n_image_length = r_image_length;
        if (emit) begin
            n_out_valid    = 1'b1;
            n_verdict      = emit_verdict;
            n_image_length = emit_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit <= jsc_pkg::LengthLimitReset;
            r_phase        <= jsc_pkg::PhIdle;
            r_skip         <= '0;
            r_seg_type     <= '0;
            r_len_high     <= '0;
            r_app_seen     <= 1'b0;
            r_prev_ff      <= 1'b0;
            r_pos          <= '0;
            r_app0         <= '0;
            r_exif         <= '0;
            r_ffed         <= '0;
            r_ffd8         <= '0;
            r_ffdb         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_length_limit <= i_cfg_length_limit;
            end
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_seg_type  <= n_seg_type;
            r_len_high  <= n_len_high;
            r_app_seen  <= n_app_seen;
            r_prev_ff   <= n_prev_ff;
            r_pos       <= n_pos;
            r_app0      <= n_app0;
            r_exif      <= n_exif;
            r_ffed      <= n_ffed;
            r_ffd8      <= n_ffd8;
            r_ffdb      <= n_ffdb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict      <= n_verdict;
        r_image_length <= n_image_length;
    end

    // counts only move on segment length bytes, never while a verdict is pending
    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_image_length = r_image_length;
    assign o_app0_total   = r_app0;
    assign o_exif_total   = r_exif;
    assign o_ffed_total   = r_ffed;
    assign o_ffd8_total   = r_ffd8;
    assign o_ffdb_total   = r_ffdb;

    `JSC_ASSERT_IMPLY(a_pending_means_done, i_clk, i_rst_n,
        r_out_valid, r_phase == jsc_pkg::PhDone)
    `JSC_ASSERT_IMPLY(a_skip_nonzero, i_clk, i_rst_n,
        r_phase == jsc_pkg::PhSkip, r_skip != 16'd0)
    `JSC_ASSERT_IMPLY(a_length_on_extract, i_clk, i_rst_n,
        r_out_valid && (r_verdict == jsc_pkg::VerdictExtract ||
                        r_verdict == jsc_pkg::VerdictTooLong),
        r_image_length != '0)
    `JSC_ASSERT_NEXT(a_verdict_follows_emit, i_clk, i_rst_n,
        emit, r_out_valid && r_phase == jsc_pkg::PhDone)

endmodule

FILE: verif/jpeg_segment_carver_tb.sv
// Self-checking testbench for the JPEG segment carver: byte stream stimulus and verdict scoreboard
`timescale 1ns / 1ps

module jpeg_segment_carver_tb;

    typedef struct packed {
        logic [jsc_pkg::VerdictWidth-1:0] verdict;
        logic [jsc_pkg::LengthWidth-1:0]  length;
        logic [jsc_pkg::CountWidth-1:0]   app0;
        logic [jsc_pkg::CountWidth-1:0]   exif;
        logic [jsc_pkg::CountWidth-1:0]   ffed;
        logic [jsc_pkg::CountWidth-1:0]   ffd8;
        logic [jsc_pkg::CountWidth-1:0]   ffdb;
    } t_carve_result;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       eod;
    } t_stream_byte;

    // Tracks the marker walk and holds the verdicts still owed by the block
    class t_verdict_board;
        logic [jsc_pkg::LimitWidth-1:0]  limit;
        logic [jsc_pkg::PhaseWidth-1:0]  phase;
        logic [15:0]                     skip_left;
        logic [7:0]                      seg_type;
        logic [7:0]                      len_high;
        logic                            app_seen;
        logic                            prev_ff;
        logic [jsc_pkg::LengthWidth-1:0] position;
        logic [jsc_pkg::CountWidth-1:0]  app0_cnt, exif_cnt, ffed_cnt, ffd8_cnt, ffdb_cnt;
        t_carve_result                   awaited[$];
        int                              failures;
        int                              live_bytes;
        int                              checked;
        int                              tally[5];

        function new();
            limit     = jsc_pkg::LengthLimitReset;
            phase     = jsc_pkg::PhIdle;
            skip_left = '0;
            seg_type  = '0;
            len_high  = '0;
            app_seen  = 1'b0;
            prev_ff   = 1'b0;
            position  = '0;
            app0_cnt  = '0;
            exif_cnt  = '0;
            ffed_cnt  = '0;
            ffd8_cnt  = '0;
            ffdb_cnt  = '0;
            failures  = 0;
            live_bytes = 0;
            checked   = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_limit(logic [jsc_pkg::LimitWidth-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void give_verdict(logic [jsc_pkg::VerdictWidth-1:0] code,
                                   logic [jsc_pkg::LengthWidth-1:0] len);
            t_carve_result r;
            r.verdict = code;
            r.length  = len;
            r.app0    = app0_cnt;
            r.exif    = exif_cnt;
            r.ffed    = ffed_cnt;
            r.ffd8    = ffd8_cnt;
            r.ffdb    = ffdb_cnt;
            awaited.push_back(r);
            phase = jsc_pkg::PhDone;
        endfunction

        function void count_segment();
            case (seg_type)
                jsc_pkg::MarkApp0: begin
                    app0_cnt++;
                    app_seen = 1'b1;
                end
                jsc_pkg::MarkExif: begin
                    exif_cnt++;
                    app_seen = 1'b1;
                end
                jsc_pkg::MarkEd:  ffed_cnt++;
                jsc_pkg::MarkSoi: ffd8_cnt++;
                jsc_pkg::MarkDqt: ffdb_cnt++;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic first, logic eod);
            logic [15:0] seg_len;
            if (first) begin
                phase     = jsc_pkg::PhSoi0;
                skip_left = '0;
                seg_type  = '0;
                len_high  = '0;
                app_seen  = 1'b0;
                prev_ff   = 1'b0;
                position  = '0;
            end
            // outside a candidate nothing happens
            if (phase == jsc_pkg::PhIdle || phase >= jsc_pkg::PhDone) return;
            live_bytes++;
            if (eod) begin
                case (phase)
                    jsc_pkg::PhSoi0, jsc_pkg::PhSoi1: begin
                        give_verdict(jsc_pkg::VerdictNotStart, '0);
                    end
                    jsc_pkg::PhMark, jsc_pkg::PhSkip: begin
                        give_verdict(app_seen ? jsc_pkg::VerdictDataEnd
                                              : jsc_pkg::VerdictNoApp, '0);
                    end
                    default: give_verdict(jsc_pkg::VerdictDataEnd, '0);
                endcase
                return;
            end
            if (position < jsc_pkg::PositionMax) position++;
            case (phase)
                jsc_pkg::PhSoi0: begin
                    if (b != jsc_pkg::MarkFf) give_verdict(jsc_pkg::VerdictNotStart, '0);
                    else phase = jsc_pkg::PhSoi1;
                end
                jsc_pkg::PhSoi1: begin
                    if (b != jsc_pkg::MarkSoi) give_verdict(jsc_pkg::VerdictNotStart, '0);
                    else phase = jsc_pkg::PhMark;
                end
                jsc_pkg::PhMark: begin
                    if (b == jsc_pkg::MarkFf) begin
                        phase = jsc_pkg::PhType;
                    end else if (app_seen) begin
                        // the byte ending the walk never counts as the FF of FF D9
                        prev_ff = 1'b0;
                        phase   = jsc_pkg::PhScan;
                    end else begin
                        give_verdict(jsc_pkg::VerdictNoApp, '0);
                    end
                end
                jsc_pkg::PhType: begin
                    seg_type = b;
                    phase    = jsc_pkg::PhLenH;
                end
                jsc_pkg::PhLenH: begin
                    len_high = b;
                    phase    = jsc_pkg::PhLenL;
                end
                jsc_pkg::PhLenL: begin
                    seg_len = {len_high, b};
                    count_segment();
                    skip_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                    phase = (skip_left != 0) ? jsc_pkg::PhSkip : jsc_pkg::PhMark;
                end
                jsc_pkg::PhSkip: begin
                    if (skip_left != 0) skip_left--;
                    if (skip_left == 0) phase = jsc_pkg::PhMark;
                end
                jsc_pkg::PhScan: begin
                    if (prev_ff && b == jsc_pkg::MarkEoi)
                        give_verdict((position < {1'b0, limit}) ? jsc_pkg::VerdictExtract
                                                                : jsc_pkg::VerdictTooLong,
                                     position);
                    else
                        prev_ff = (b == jsc_pkg::MarkFf);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(t_carve_result got);
            t_carve_result want;
            if (awaited.size() == 0) begin
                $error("verdict %0d arrived with none outstanding", got.verdict);
                failures++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.verdict <= jsc_pkg::VerdictNotStart) tally[want.verdict]++;
            compare_field("verdict",      32'(want.verdict), 32'(got.verdict));
            compare_field("image_length", 32'(want.length),  32'(got.length));
            compare_field("app0_total",   want.app0, got.app0);
            compare_field("exif_total",   want.exif, got.exif);
            compare_field("ffed_total",   want.ffed, got.ffed);
            compare_field("ffd8_total",   want.ffd8, got.ffd8);
            compare_field("ffdb_total",   want.ffdb, got.ffdb);
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [7:0]                       i_data_byte = 8'h00;
    logic                             i_first_byte = 1'b0;
    logic                             i_end_of_data = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [jsc_pkg::VerdictWidth-1:0] o_verdict;
    logic [jsc_pkg::LengthWidth-1:0]  o_image_length;
    logic [jsc_pkg::CountWidth-1:0]   o_app0_total;
    logic [jsc_pkg::CountWidth-1:0]   o_exif_total;
    logic [jsc_pkg::CountWidth-1:0]   o_ffed_total;
    logic [jsc_pkg::CountWidth-1:0]   o_ffd8_total;
    logic [jsc_pkg::CountWidth-1:0]   o_ffdb_total;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [jsc_pkg::LimitWidth-1:0]   i_cfg_length_limit = '0;

    t_verdict_board board;
    t_stream_byte   byte_plan[$];
    logic           quiet = 1'b0;
    int             candidates = 0;

    jpeg_segment_carver u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_first_byte       (i_first_byte),
        .i_end_of_data      (i_end_of_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_verdict          (o_verdict),
        .o_image_length     (o_image_length),
        .o_app0_total       (o_app0_total),
        .o_exif_total       (o_exif_total),
        .o_ffed_total       (o_ffed_total),
        .o_ffd8_total       (o_ffd8_total),
        .o_ffdb_total       (o_ffdb_total),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_length_limit (i_cfg_length_limit)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 32);
    end

    // every transaction is seen here at the rising edge
    always @(posedge i_clk) begin
        t_carve_result seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.set_limit(i_cfg_length_limit);
            if (i_in_valid && !o_in_stall)
                board.note_byte(i_data_byte, i_first_byte, i_end_of_data);
            if (o_out_valid && !i_out_stall) begin
                seen.verdict = o_verdict;
                seen.length  = o_image_length;
                seen.app0    = o_app0_total;
                seen.exif    = o_exif_total;
                seen.ffed    = o_ffed_total;
                seen.ffd8    = o_ffd8_total;
                seen.ffdb    = o_ffdb_total;
                board.check_verdict(seen);
            end
        end
    end

    function automatic logic [7:0] any_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic void push_byte(logic [7:0] data, logic first, logic eod);
        t_stream_byte it;
        it.data  = data;
        it.first = first;
        it.eod   = eod;
        byte_plan.push_back(it);
    endfunction

    // One candidate image: mostly a well-formed walk, sometimes noise, cut short or corrupted
    function automatic void plan_candidate();
        int          start;
        int          segs;
        int          k;
        int          cut;
        logic [7:0]  seg_kind;
        logic [15:0] seg_len;
        start = byte_plan.size();
        candidates++;
        if ($urandom_range(99) < 8) begin
            push_byte(any_byte(), 1'b1, $urandom_range(9) == 0);
            repeat ($urandom_range(4))
                push_byte(any_byte(), $urandom_range(7) == 0, $urandom_range(9) == 0);
            return;
        end
        push_byte(jsc_pkg::MarkFf, 1'b1, 1'b0);
        push_byte(jsc_pkg::MarkSoi, 1'b0, 1'b0);
        segs = $urandom_range(4);
        for (int s = 0; s < segs; s++) begin
            case ($urandom_range(9))
                0, 1:    seg_kind = jsc_pkg::MarkApp0;
                2, 3:    seg_kind = jsc_pkg::MarkExif;
                4:       seg_kind = jsc_pkg::MarkEd;
                5:       seg_kind = jsc_pkg::MarkSoi;
                6:       seg_kind = jsc_pkg::MarkDqt;
                default: seg_kind = any_byte();
            endcase
            case ($urandom_range(19))
                0:       seg_len = 16'($urandom_range(1));
                1:       seg_len = {any_byte(), any_byte()};
                default: seg_len = 16'($urandom_range(2, 10));
            endcase
            push_byte(jsc_pkg::MarkFf, 1'b0, 1'b0);
            push_byte(seg_kind, 1'b0, 1'b0);
            push_byte(seg_len[15:8], 1'b0, 1'b0);
            push_byte(seg_len[7:0], 1'b0, 1'b0);
            if (seg_len > 16'd40) begin
                // long payload: data runs out part way through
                repeat ($urandom_range(1, 6)) push_byte(any_byte(), 1'b0, 1'b0);
                push_byte(any_byte(), 1'b0, 1'b1);
                return;
            end
            for (k = 2; k < seg_len; k++) push_byte(any_byte(), 1'b0, 1'b0);
        end
        push_byte(8'($urandom_range(254)), 1'b0, 1'b0);
        repeat ($urandom_range(12))
            push_byte(($urandom_range(3) == 0) ? jsc_pkg::MarkFf : any_byte(), 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkFf, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkEoi, 1'b0, 1'b0);
        if ($urandom_range(6) == 0)
            repeat ($urandom_range(1, 3)) push_byte(any_byte(), 1'b0, $urandom_range(3) == 0);
        if ($urandom_range(99) < 25) begin
            cut = $urandom_range(start + 1, byte_plan.size() - 1);
            while (byte_plan.size() > cut) void'(byte_plan.pop_back());
            if ($urandom_range(9) < 7) push_byte(any_byte(), 1'b0, 1'b1);
        end else if ($urandom_range(99) < 6) begin
            k = $urandom_range(start + 1, byte_plan.size() - 1);
            byte_plan[k].data = any_byte();
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the last transaction
    task automatic send_plan();
        t_stream_byte it;
        while (byte_plan.size() != 0) begin
            it = byte_plan.pop_front();
            while (!quiet && $urandom_range(99) < 32) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_in_valid    <= 1'b1;
            i_data_byte   <= it.data;
            i_first_byte  <= it.first;
            i_end_of_data <= it.eod;
            do @(posedge i_clk); while (o_in_stall);
            @(negedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [jsc_pkg::LimitWidth-1:0] value);
        i_cfg_valid        <= 1'b1;
        i_cfg_length_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [jsc_pkg::LimitWidth-1:0] limits[6];
        int                             target;
        board = new();
        limits[0] = '0;
        limits[1] = '1;
        limits[2] = 24'd40;
        limits[3] = 24'($urandom_range(25, 80));
        limits[4] = 24'($urandom);
        limits[5] = jsc_pkg::LengthLimitReset;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stray bytes before any candidate, then one-byte and broken starts
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b1);
        push_byte(8'h3C, 1'b1, 1'b1);
        push_byte(jsc_pkg::MarkFf, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        // APP0 with one payload byte; walk ends on D9 which must not close the image
        push_byte(jsc_pkg::MarkFf, 1'b1, 1'b0);
        push_byte(jsc_pkg::MarkSoi, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkFf, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkApp0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h03, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkEoi, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkFf, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkEoi, 1'b0, 1'b0);
        // DQT with a short length, then a huge ED segment cut off in its payload
        push_byte(jsc_pkg::MarkFf, 1'b1, 1'b0);
        push_byte(jsc_pkg::MarkSoi, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkFf, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkDqt, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkFf, 1'b0, 1'b0);
        push_byte(jsc_pkg::MarkEd, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b1);
        send_plan();

        for (int p = 0; p < 6; p++) begin
            // close any open candidate so the limit changes between images
            push_byte(any_byte(), 1'b0, 1'b1);
            send_plan();
            settle();
            write_limit(limits[p]);
            quiet  = (p == 2);
            target = board.live_bytes + 275;
            while (board.live_bytes < target) begin
                plan_candidate();
                send_plan();
            end
        end
        quiet = 1'b0;

        settle();
        repeat (10) @(negedge i_clk);
        $display("Covered %0d live bytes in %0d candidates over six length limits.",
                 board.live_bytes, candidates);
        $display("Checked %0d verdicts: %0d no app, %0d extract, %0d too long,",
                 board.checked, board.tally[0], board.tally[1], board.tally[2]);
        $display("  %0d ended, %0d not start.", board.tally[3], board.tally[4]);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/jsc_pkg.sv
rtl/jpeg_segment_carver.sv
verif/jpeg_segment_carver_tb.sv
